/* design/gbpf_pkg.sv */
// ----------------------------------------------------------------------------
// gbpf_pkg
// shared constants and types of the page framebuffer text blitter
// ----------------------------------------------------------------------------
package gbpf_pkg;

   // operation codes
   localparam logic [2:0] OP_FILL   = 3'd0;
   localparam logic [2:0] OP_CURSOR = 3'd1;
   localparam logic [2:0] OP_LOAD   = 3'd2;
   localparam logic [2:0] OP_DRAW   = 3'd3;
   localparam logic [2:0] OP_READ   = 3'd4;

   // register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_FONT_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FONT_HEIGHT = 2'd1;
   localparam int CSR_DATA_W = 8;

   localparam int FW_W = 5;
   localparam int FH_W = 6;
   localparam logic [FW_W-1:0] FONT_WIDTH_RST  = 5'd7;
   localparam logic [FH_W-1:0] FONT_HEIGHT_RST = 6'd10;

   localparam logic [7:0] FIRST_CODE = 8'd32;
   localparam int GLYPH_W = 16;

   // request to the shared pixel merge unit
   typedef struct packed {
      logic [7:0]         old_byte;
      logic [GLYPH_W-1:0] bits;
      logic [FW_W-1:0]    col;
      logic [2:0]         bit_sel;
      logic               white;
   } pix_req_type;

   typedef struct packed {
      logic [7:0] new_byte;
      logic       wr;
   } pix_rsp_type;

endpackage

/* design/gbpf_ifs.sv */
// ----------------------------------------------------------------------------
// gbpf channel interfaces
// request, response and register write channels with valid/ready
// ----------------------------------------------------------------------------
interface gbpf_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  op;
   logic        color_white;
   logic [7:0]  pos_x;
   logic [7:0]  pos_y;
   logic [7:0]  char_code;
   logic [4:0]  glyph_row_index;
   logic [15:0] glyph_bits;
   logic [8:0]  byte_index;

   modport source (output valid, op, color_white, pos_x, pos_y, char_code,
                   glyph_row_index, glyph_bits, byte_index, input ready);
   modport sink (input valid, op, color_white, pos_x, pos_y, char_code,
                 glyph_row_index, glyph_bits, byte_index, output ready);
endinterface

interface gbpf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic       drawn;
   logic [7:0] cursor_column;

   modport source (output valid, read_data, drawn, cursor_column, input ready);
   modport sink (input valid, read_data, drawn, cursor_column, output ready);
endinterface

interface gbpf_csr_if;
   logic                           valid;
   logic                           ready;
   logic [gbpf_pkg::CSR_IDX_W-1:0]  index;
   logic [gbpf_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* design/glyph_blit_page_framebuffer_core.sv */
// ----------------------------------------------------------------------------
// glyph_blit_page_framebuffer_core
// Page-organized monochrome frame store with a text cursor and a glyph store.
// One request is taken at a time and answered with one response. After reset
// a clearing pass zeroes all DISPLAY_WIDTH * pages bytes (512 by default) of
// the frame store before the first request is taken; a fill makes the same
// pass with the fill byte. A character draw walks the glyph row by row and
// pixel by pixel through one shared merge unit with a read-modify-write on
// the frame memory port. The next request is accepted while a response
// still waits to be taken.
// ----------------------------------------------------------------------------
module glyph_blit_page_framebuffer_core #(
   parameter int DISPLAY_WIDTH   = 128,
   parameter int DISPLAY_HEIGHT  = 32,
   parameter int MAX_FONT_HEIGHT = 32,
   parameter int GLYPH_COUNT     = 95
) (
   input  logic        clock,
   input  logic        reset,
   gbpf_req_if.sink    req_ch,
   gbpf_rsp_if.source  rsp_ch,
   gbpf_csr_if.sink    csr_ch
);

   localparam int PAGE_COUNT  = (DISPLAY_HEIGHT + 7) / 8;
   localparam int FRAME_BYTES = DISPLAY_WIDTH * PAGE_COUNT;
   localparam int GLYPH_ROWS  = GLYPH_COUNT * MAX_FONT_HEIGHT;
   localparam int FA_W        = $clog2(FRAME_BYTES);
   localparam int GA_W        = $clog2(GLYPH_ROWS);
   localparam logic [FA_W-1:0] LAST_BYTE = FA_W'(FRAME_BYTES - 1);
   localparam logic [8:0] CODE_END = 9'(gbpf_pkg::FIRST_CODE) + 9'(GLYPH_COUNT);
   localparam logic [8:0] WIDTH_LIM  = 9'(DISPLAY_WIDTH);
   localparam logic [8:0] HEIGHT_LIM = 9'(DISPLAY_HEIGHT);

   typedef enum logic [8:0] {
      ST_CLEAR  = 9'b000000001,
      ST_IDLE   = 9'b000000010,
      ST_FILL   = 9'b000000100,
      ST_RDWAIT = 9'b000001000,
      ST_ROW    = 9'b000010000,
      ST_GWAIT  = 9'b000100000,
      ST_COL    = 9'b001000000,
      ST_WR     = 9'b010000000,
      ST_DONE   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   logic [FA_W-1:0]           fcnt_ff, fcnt_in;
   logic [7:0]                fill_byte_ff, fill_byte_in;
   logic [7:0]                cursor_col_ff, cursor_col_in;
   logic [7:0]                cursor_row_ff, cursor_row_in;
   logic [gbpf_pkg::FW_W-1:0] fw_ff, fw_in;
   logic [gbpf_pkg::FH_W-1:0] fh_ff, fh_in;
   logic [GA_W-1:0]           gbase_ff, gbase_in;
   logic                      white_ff, white_in;
   logic [gbpf_pkg::FH_W-1:0] row_ff, row_in;
   logic [gbpf_pkg::FW_W-1:0] col_ff, col_in;
   logic [FA_W-1:0]           base_ff, base_in;
   logic [2:0]                bitsel_ff, bitsel_in;
   logic [15:0]               gbits_ff, gbits_in;
   logic [FA_W-1:0]           faddr_ff, faddr_in;
   logic                      in_range_ff, in_range_in;
   logic [7:0]                res_read_ff, res_read_in;
   logic                      res_drawn_ff, res_drawn_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [7:0]                rsp_read_ff, rsp_read_in;
   logic                      rsp_drawn_ff, rsp_drawn_in;
   logic [7:0]                rsp_col_ff, rsp_col_in;

   logic                      req_fire;
   logic                      has_glyph;
   logic                      fits;
   logic [GA_W-1:0]           req_gbase;
   logic                      row_in_glyph;
   logic [8:0]                py;

   logic                      fram_wr_en, fram_rd_en;
   logic [FA_W-1:0]           fram_wr_addr, fram_rd_addr;
   logic [7:0]                fram_wr_data, fram_rd_data;
   logic                      gram_wr_en, gram_rd_en;
   logic [GA_W-1:0]           gram_wr_addr, gram_rd_addr;
   logic [15:0]               gram_rd_data;

   gbpf_pkg::pix_req_type     pix_req;
   gbpf_pkg::pix_rsp_type     pix_rsp;

   gbpf_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_frame_ram (
      .clock   (clock),
      .wr_en   (fram_wr_en),
      .wr_addr (fram_wr_addr),
      .wr_data (fram_wr_data),
      .rd_en   (fram_rd_en),
      .rd_addr (fram_rd_addr),
      .rd_data (fram_rd_data)
   );

   gbpf_ram #(.WIDTH(16), .DEPTH(GLYPH_ROWS)) u_glyph_ram (
      .clock   (clock),
      .wr_en   (gram_wr_en),
      .wr_addr (gram_wr_addr),
      .wr_data (req_ch.glyph_bits),
      .rd_en   (gram_rd_en),
      .rd_addr (gram_rd_addr),
      .rd_data (gram_rd_data)
   );

   gbpf_pix_unit u_pix_unit (
      .pix_req (pix_req),
      .pix_rsp (pix_rsp)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;
   assign req_fire     = req_ch.valid && req_ch.ready;

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.read_data     = rsp_read_ff;
   assign rsp_ch.drawn         = rsp_drawn_ff;
   assign rsp_ch.cursor_column = rsp_col_ff;

   assign has_glyph = (req_ch.char_code >= gbpf_pkg::FIRST_CODE) &&
                      ({1'b0, req_ch.char_code} < CODE_END);
   assign fits      = ({1'b0, cursor_col_ff} + 9'(fw_ff) < WIDTH_LIM) &&
                      ({1'b0, cursor_row_ff} + 9'(fh_ff) < HEIGHT_LIM);
   assign req_gbase = GA_W'(32'(req_ch.char_code - gbpf_pkg::FIRST_CODE) *
                            MAX_FONT_HEIGHT);
   assign row_in_glyph = 32'(row_ff) < MAX_FONT_HEIGHT;
   assign py           = {1'b0, cursor_row_ff} + 9'(row_ff);

   // glyph store ports
   assign gram_wr_en   = req_fire && (req_ch.op == gbpf_pkg::OP_LOAD) && has_glyph &&
                         (32'(req_ch.glyph_row_index) < MAX_FONT_HEIGHT);
   assign gram_wr_addr = req_gbase + GA_W'(req_ch.glyph_row_index);
   assign gram_rd_en   = (state_ff == ST_ROW) && (row_ff != fh_ff) && row_in_glyph;
   assign gram_rd_addr = gbase_ff + GA_W'(row_ff);

   // merge unit sees the byte read in the previous cycle
   always_comb begin
      pix_req.old_byte = fram_rd_data;
      pix_req.bits     = gbits_ff;
      pix_req.col      = col_ff;
      pix_req.bit_sel  = bitsel_ff;
      pix_req.white    = white_ff;
   end

   // frame store ports
   always_comb begin
      fram_wr_en   = 1'b0;
      fram_wr_addr = faddr_ff;
      fram_wr_data = pix_rsp.new_byte;
      fram_rd_en   = 1'b0;
      fram_rd_addr = base_ff + FA_W'(col_ff);
      case (state_ff)
         ST_CLEAR: begin
            fram_wr_en   = 1'b1;
            fram_wr_addr = fcnt_ff;
            fram_wr_data = 8'h00;
         end
         ST_FILL: begin
            fram_wr_en   = 1'b1;
            fram_wr_addr = fcnt_ff;
            fram_wr_data = fill_byte_ff;
         end
         ST_IDLE: begin
            fram_rd_en   = req_fire && (req_ch.op == gbpf_pkg::OP_READ);
            fram_rd_addr = FA_W'(req_ch.byte_index);
         end
         ST_COL: begin
            fram_rd_en = (col_ff != fw_ff);
         end
         ST_WR: begin
            fram_wr_en = pix_rsp.wr;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      fcnt_in       = fcnt_ff;
      fill_byte_in  = fill_byte_ff;
      cursor_col_in = cursor_col_ff;
      cursor_row_in = cursor_row_ff;
      fw_in         = fw_ff;
      fh_in         = fh_ff;
      gbase_in      = gbase_ff;
      white_in      = white_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      base_in       = base_ff;
      bitsel_in     = bitsel_ff;
      gbits_in      = gbits_ff;
      faddr_in      = faddr_ff;
      in_range_in   = in_range_ff;
      res_read_in   = res_read_ff;
      res_drawn_in  = res_drawn_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_read_in   = rsp_read_ff;
      rsp_drawn_in  = rsp_drawn_ff;
      rsp_col_in    = rsp_col_ff;

      if (csr_ch.valid) begin
         if (csr_ch.index == gbpf_pkg::CSR_FONT_WIDTH) begin
            fw_in = csr_ch.data[gbpf_pkg::FW_W-1:0];
         end else if (csr_ch.index == gbpf_pkg::CSR_FONT_HEIGHT) begin
            fh_in = csr_ch.data[gbpf_pkg::FH_W-1:0];
         end
      end

      case (state_ff)
         ST_CLEAR: begin
            fcnt_in = fcnt_ff + 1'b1;
            if (fcnt_ff == LAST_BYTE) begin
               fcnt_in  = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               res_read_in  = 8'h00;
               res_drawn_in = 1'b0;
               state_in     = ST_DONE;
               case (req_ch.op)
                  gbpf_pkg::OP_FILL: begin
                     fill_byte_in = {8{req_ch.color_white}};
                     fcnt_in      = '0;
                     state_in     = ST_FILL;
                  end
                  gbpf_pkg::OP_CURSOR: begin
                     cursor_col_in = req_ch.pos_x;
                     cursor_row_in = req_ch.pos_y;
                  end
                  gbpf_pkg::OP_DRAW: begin
                     if (has_glyph && fits) begin
                        gbase_in = req_gbase;
                        white_in = req_ch.color_white;
                        row_in   = '0;
                        state_in = ST_ROW;
                     end
                  end
                  gbpf_pkg::OP_READ: begin
                     in_range_in = 32'(req_ch.byte_index) < FRAME_BYTES;
                     state_in    = ST_RDWAIT;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FILL: begin
            fcnt_in = fcnt_ff + 1'b1;
            if (fcnt_ff == LAST_BYTE) begin
               fcnt_in  = '0;
               state_in = ST_DONE;
            end
         end
         ST_RDWAIT: begin
            res_read_in = in_range_ff ? fram_rd_data : 8'h00;
            state_in    = ST_DONE;
         end
         ST_ROW: begin
            if (row_ff == fh_ff) begin
               cursor_col_in = cursor_col_ff + 8'(fw_ff);
               res_drawn_in  = 1'b1;
               state_in      = ST_DONE;
            end else begin
               // fit check keeps py inside the display
               base_in   = FA_W'(32'(py[8:3]) * DISPLAY_WIDTH + 32'(cursor_col_ff));
               bitsel_in = py[2:0];
               col_in    = '0;
               state_in  = ST_GWAIT;
            end
         end
         ST_GWAIT: begin
            gbits_in = row_in_glyph ? gram_rd_data : 16'h0000;
            state_in = ST_COL;
         end
         ST_COL: begin
            if (col_ff == fw_ff) begin
               row_in   = row_ff + 1'b1;
               state_in = ST_ROW;
            end else begin
               faddr_in = base_ff + FA_W'(col_ff);
               state_in = ST_WR;
            end
         end
         ST_WR: begin
            col_in   = col_ff + 1'b1;
            state_in = ST_COL;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_read_in  = res_read_ff;
               rsp_drawn_in = res_drawn_ff;
               rsp_col_in   = cursor_col_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         fcnt_ff       <= '0;
         cursor_col_ff <= 8'h00;
         cursor_row_ff <= 8'h00;
         fw_ff         <= gbpf_pkg::FONT_WIDTH_RST;
         fh_ff         <= gbpf_pkg::FONT_HEIGHT_RST;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fcnt_ff       <= fcnt_in;
         cursor_col_ff <= cursor_col_in;
         cursor_row_ff <= cursor_row_in;
         fw_ff         <= fw_in;
         fh_ff         <= fh_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fill_byte_ff <= fill_byte_in;
      gbase_ff     <= gbase_in;
      white_ff     <= white_in;
      row_ff       <= row_in;
      col_ff       <= col_in;
      base_ff      <= base_in;
      bitsel_ff    <= bitsel_in;
      gbits_ff     <= gbits_in;
      faddr_ff     <= faddr_in;
      in_range_ff  <= in_range_in;
      res_read_ff  <= res_read_in;
      res_drawn_ff <= res_drawn_in;
      rsp_read_ff  <= rsp_read_in;
      rsp_drawn_ff <= rsp_drawn_in;
      rsp_col_ff   <= rsp_col_in;
   end

   // no transaction is taken while the clearing pass runs
   a_clear_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_ch.ready)
      else $error("request taken during clearing pass");

   // glyph rows are written only in the cycle a request is taken
   a_glyph_wr_idle: assert property (@(posedge clock) disable iff (reset)
      gram_wr_en |-> (state_ff == ST_IDLE))
      else $error("glyph store written outside idle");

   // a pixel write always hits a column inside the glyph width
   a_col_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WR) |-> (col_ff < fw_ff))
      else $error("pixel column beyond font width");

   // each pixel write returns to the column step
   a_wr_to_col: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WR) |=> (state_ff == ST_COL))
      else $error("pixel write not followed by column step");

endmodule

/* design/gbpf_ram.sv */
// ----------------------------------------------------------------------------
// gbpf_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
module gbpf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/gbpf_pix_unit.sv */
// ----------------------------------------------------------------------------
// gbpf_pix_unit
// merges one glyph pixel into a frame byte
// ----------------------------------------------------------------------------
module gbpf_pix_unit (
   input  gbpf_pkg::pix_req_type pix_req,
   output gbpf_pkg::pix_rsp_type pix_rsp
);

   logic       on;
   logic [7:0] mask;

   // columns past the glyph row width count as clear
   assign on   = !pix_req.col[4] && pix_req.bits[4'd15 - pix_req.col[3:0]];
   assign mask = 8'd1 << pix_req.bit_sel;

   always_comb begin
      pix_rsp.new_byte = on ? (pix_req.old_byte | mask) : (pix_req.old_byte & ~mask);
      pix_rsp.wr       = on || !pix_req.white;
   end

endmodule
